// ----- sv/ppm_pkg.sv -----
// ----------------------------------------------------------------------------
// PPM P6 stream parser package
// Character codes, result kinds, error codes and sizing shared by the
// parser modules and the port checker.
// ----------------------------------------------------------------------------
package ppm_pkg;

   // default width of the image size, column and row fields
   localparam int unsigned DIM_BITS_DEFAULT = 16;

   // depth of the result queue; must leave room for the two results of one byte
   localparam int unsigned QUEUE_DEPTH = 4;

   // characters of the file format
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_SIX   = 8'h36;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   // the only maxval accepted
   localparam int unsigned MAXVAL_REQUIRED = 255;

   // result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // error codes
   localparam logic [2:0] ERR_BAD_MAGIC  = 3'd0;
   localparam logic [2:0] ERR_EARLY_END  = 3'd1;
   localparam logic [2:0] ERR_ZERO_SIZE  = 3'd2;
   localparam logic [2:0] ERR_BAD_MAXVAL = 3'd3;
   localparam logic [2:0] ERR_SHORT_DATA = 3'd4;
   localparam logic [2:0] ERR_OVERFLOW   = 3'd5;

   // last pixel channel (blue)
   localparam logic [1:0] CHAN_BLUE = 2'd2;

   // packed width of one result: kind, width, height, pixel, channel,
   // column, row, last of image, error code, last result
   function automatic int unsigned rsp_bits(input int unsigned dim);
      return 4 * dim + 17;
   endfunction

endpackage

// ----- sv/ppm_engine.sv -----
// ----------------------------------------------------------------------------
// PPM parse engine
// Holds the parser state and works one byte per step: header scan, number
// accumulation, header checks and pixel tagging. Gives up to two results.
// ----------------------------------------------------------------------------
module ppm_engine #(
   parameter int unsigned DIM_BITS = ppm_pkg::DIM_BITS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       step_i,
   input  logic [7:0]                                 byte_i,
   input  logic                                       eof_i,
   output logic [1:0]                                 push_cnt_o,
   output logic [ppm_pkg::rsp_bits(DIM_BITS)-1:0]     rsp0_o,
   output logic [ppm_pkg::rsp_bits(DIM_BITS)-1:0]     rsp1_o
);
   import ppm_pkg::*;

   typedef enum logic [3:0] {
      PH_MAGIC_P,
      PH_MAGIC_6,
      PH_WS_W,
      PH_NUM_W,
      PH_WS_H,
      PH_NUM_H,
      PH_WS_M,
      PH_NUM_M,
      PH_TERM,
      PH_CR,
      PH_PIX,
      PH_DONE,
      PH_IDLE
   } phase_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [DIM_BITS-1:0] width;
      logic [DIM_BITS-1:0] height;
      logic [7:0]          pixel;
      logic [1:0]          channel;
      logic [DIM_BITS-1:0] column;
      logic [DIM_BITS-1:0] row;
      logic                last_of_image;
      logic [2:0]          error_code;
      logic                last_result;
   } rsp_type;

   phase_type           phase_ff,   phase_in;
   logic                comment_ff, comment_in;
   logic [DIM_BITS-1:0] acc_ff,     acc_in;
   logic [DIM_BITS-1:0] width_ff,   width_in;
   logic [DIM_BITS-1:0] height_ff,  height_in;
   logic [DIM_BITS-1:0] col_ff,     col_in;
   logic [DIM_BITS-1:0] row_ff,     row_in;
   logic [1:0]          chan_ff,    chan_in;

   logic                is_digit;
   logic [3:0]          digit;
   logic                in_ws;
   logic [DIM_BITS-1:0] acc_base;
   logic [DIM_BITS+3:0] acc_prod;
   logic                acc_ovf;
   logic [DIM_BITS:0]   col_plus;
   logic [DIM_BITS:0]   row_plus;
   logic                pix_last;
   logic                sel_w;
   logic                sel_h;
   logic                num_go;
   logic                emit_norm;
   logic                hdr_put;
   logic                pix_put;
   logic                fail_put;
   logic [2:0]          fail_code;
   logic                hdr_phase;
   logic                eof_err;
   logic [1:0]          n_res;
   rsp_type             hdr_res;
   rsp_type             pix_res;
   rsp_type             err_res;
   rsp_type             eof_res;
   rsp_type             r0;
   rsp_type             r1;

   // classify the byte and form the next decimal value
   assign is_digit = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
   assign digit    = 4'((byte_i - CHAR_ZERO) & 8'h0F);
   assign in_ws    = (phase_ff == PH_WS_W) || (phase_ff == PH_WS_H) || (phase_ff == PH_WS_M);
   assign acc_base = in_ws ? '0 : acc_ff;
   assign acc_prod = ({4'b0000, acc_base} << 3) + ({4'b0000, acc_base} << 1)
                   + (DIM_BITS+4)'(digit);
   assign acc_ovf  = |acc_prod[DIM_BITS+3:DIM_BITS];

   // position of the pixel following the current one
   assign col_plus = {1'b0, col_ff} + 1'b1;
   assign row_plus = {1'b0, row_ff} + 1'b1;
   assign pix_last = (chan_ff == CHAN_BLUE) && (col_plus == {1'b0, width_ff})
                   && (row_plus == {1'b0, height_ff});

   assign sel_w = (phase_ff == PH_WS_W) || (phase_ff == PH_NUM_W);
   assign sel_h = (phase_ff == PH_WS_H) || (phase_ff == PH_NUM_H);

   // next state for one byte
   always_comb begin
      phase_in   = phase_ff;
      comment_in = comment_ff;
      acc_in     = acc_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      chan_in    = chan_ff;
      num_go     = 1'b0;
      emit_norm  = 1'b0;
      hdr_put    = 1'b0;
      pix_put    = 1'b0;
      fail_put   = 1'b0;
      fail_code  = ERR_BAD_MAGIC;

      // magic, whitespace and the byte-level phases
      unique case (phase_ff)
         PH_MAGIC_P: begin
            if (byte_i == CHAR_P) begin
               phase_in = PH_MAGIC_6;
            end else begin
               fail_put = 1'b1;
               fail_code = ERR_BAD_MAGIC;
            end
         end
         PH_MAGIC_6: begin
            if (byte_i == CHAR_SIX) begin
               phase_in = PH_WS_W;
            end else begin
               fail_put = 1'b1;
               fail_code = ERR_BAD_MAGIC;
            end
         end
         PH_WS_W, PH_WS_H, PH_WS_M: begin
            if (comment_ff) begin
               if (byte_i == CHAR_LF) begin
                  comment_in = 1'b0;
               end
            end else if (byte_i == CHAR_HASH) begin
               comment_in = 1'b1;
            end else if (byte_i > CHAR_SPACE) begin
               num_go = 1'b1;
            end
         end
         PH_NUM_W, PH_NUM_H, PH_NUM_M: begin
            num_go = 1'b1;
         end
         PH_TERM: begin
            if (byte_i == CHAR_LF) begin
               phase_in = PH_PIX;
            end else if (byte_i == CHAR_CR) begin
               phase_in = PH_CR;
            end else begin
               phase_in = PH_PIX;
               emit_norm = 1'b1;
            end
         end
         PH_CR: begin
            phase_in = PH_PIX;
            emit_norm = (byte_i != CHAR_LF);
         end
         PH_PIX: begin
            emit_norm = 1'b1;
         end
         PH_DONE, PH_IDLE: begin
         end
         default: begin
         end
      endcase

      // accumulate a digit, or end the number and run the next phases
      if (num_go) begin
         if (is_digit) begin
            if (acc_ovf) begin
               fail_put = 1'b1;
               fail_code = ERR_OVERFLOW;
            end else begin
               acc_in = acc_prod[DIM_BITS-1:0];
               phase_in = sel_w ? PH_NUM_W : (sel_h ? PH_NUM_H : PH_NUM_M);
            end
         end else begin
            acc_in = '0;
            priority if (sel_w) begin
               width_in = acc_base;
               if (byte_i == CHAR_HASH) begin
                  comment_in = 1'b1;
                  phase_in = PH_WS_H;
               end else if (byte_i <= CHAR_SPACE) begin
                  phase_in = PH_WS_H;
               end else begin
                  // height and maxval both end empty on this byte
                  fail_put = 1'b1;
                  fail_code = ERR_ZERO_SIZE;
               end
            end else if (sel_h) begin
               height_in = acc_base;
               if (byte_i == CHAR_HASH) begin
                  comment_in = 1'b1;
                  phase_in = PH_WS_M;
               end else if (byte_i <= CHAR_SPACE) begin
                  phase_in = PH_WS_M;
               end else begin
                  // maxval ends empty on this byte
                  fail_put = 1'b1;
                  fail_code = (width_ff == '0 || acc_base == '0) ? ERR_ZERO_SIZE
                                                                : ERR_BAD_MAXVAL;
               end
            end else begin
               if (width_ff == '0 || height_ff == '0) begin
                  fail_put = 1'b1;
                  fail_code = ERR_ZERO_SIZE;
               end else if (acc_base != DIM_BITS'(MAXVAL_REQUIRED)) begin
                  fail_put = 1'b1;
                  fail_code = ERR_BAD_MAXVAL;
               end else begin
                  hdr_put = 1'b1;
                  col_in = '0;
                  row_in = '0;
                  chan_in = '0;
                  if (byte_i == CHAR_LF) begin
                     phase_in = PH_PIX;
                  end else if (byte_i == CHAR_CR) begin
                     phase_in = PH_CR;
                  end else begin
                     // terminator byte is the first red component
                     phase_in = PH_PIX;
                     pix_put = 1'b1;
                     chan_in = 2'd1;
                  end
               end
            end
         end
      end

      // tag a pixel byte and advance channel, column and row
      if (emit_norm) begin
         pix_put = 1'b1;
         if (pix_last) begin
            phase_in = PH_DONE;
         end else if (chan_ff != CHAN_BLUE) begin
            chan_in = chan_ff + 2'd1;
         end else begin
            chan_in = '0;
            if (col_plus >= {1'b0, width_ff}) begin
               col_in = '0;
               row_in = row_plus[DIM_BITS-1:0];
            end else begin
               col_in = col_plus[DIM_BITS-1:0];
            end
         end
      end

      // an error parks the parser until the end of the file
      if (fail_put) begin
         phase_in = PH_IDLE;
         comment_in = 1'b0;
      end
   end

   // end of file while the header or the pixel data is still open
   assign hdr_phase = (phase_in == PH_MAGIC_P) || (phase_in == PH_MAGIC_6)
                   || (phase_in == PH_WS_W) || (phase_in == PH_NUM_W)
                   || (phase_in == PH_WS_H) || (phase_in == PH_NUM_H)
                   || (phase_in == PH_WS_M) || (phase_in == PH_NUM_M);
   assign eof_err = eof_i && (hdr_phase || (phase_in == PH_TERM)
                   || (phase_in == PH_CR) || (phase_in == PH_PIX));

   // build the result items
   always_comb begin
      hdr_res = '0;
      hdr_res.kind = KIND_HEADER;
      hdr_res.width = width_ff;
      hdr_res.height = height_ff;

      pix_res = '0;
      pix_res.kind = KIND_PIXEL;
      pix_res.pixel = byte_i;
      pix_res.channel = hdr_put ? 2'd0 : chan_ff;
      pix_res.column = hdr_put ? '0 : col_ff;
      pix_res.row = hdr_put ? '0 : row_ff;
      pix_res.last_of_image = !hdr_put && pix_last;

      err_res = '0;
      err_res.kind = KIND_ERROR;
      err_res.error_code = fail_code;

      eof_res = '0;
      eof_res.kind = KIND_ERROR;
      eof_res.error_code = hdr_phase ? ERR_EARLY_END : ERR_SHORT_DATA;

      r0 = '0;
      r1 = '0;
      n_res = 2'd0;
      priority if (hdr_put) begin
         r0 = hdr_res;
         n_res = 2'd1;
         if (pix_put) begin
            r1 = pix_res;
            n_res = 2'd2;
         end
      end else if (pix_put) begin
         r0 = pix_res;
         n_res = 2'd1;
      end else if (fail_put) begin
         r0 = err_res;
         n_res = 2'd1;
      end

      // end-of-file error takes the second place when the first is taken, replacing any second result
      if (eof_err) begin
         if (n_res == 2'd0) begin
            r0 = eof_res;
            n_res = 2'd1;
         end else begin
            r1 = eof_res;
            n_res = 2'd2;
         end
      end

      // flag the last result of this byte
      if (n_res == 2'd1) begin
         r0.last_result = 1'b1;
      end else if (n_res == 2'd2) begin
         r1.last_result = 1'b1;
      end
   end

   assign push_cnt_o = step_i ? n_res : 2'd0;
   assign rsp0_o     = r0;
   assign rsp1_o     = r1;

   // hold parser state; rearm after the last byte of a file
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MAGIC_P;
         comment_ff <= 1'b0;
         acc_ff     <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         chan_ff    <= '0;
      end else if (step_i) begin
         if (eof_i) begin
            phase_ff   <= PH_MAGIC_P;
            comment_ff <= 1'b0;
            acc_ff     <= '0;
            width_ff   <= '0;
            height_ff  <= '0;
            col_ff     <= '0;
            row_ff     <= '0;
            chan_ff    <= '0;
         end else begin
            phase_ff   <= phase_in;
            comment_ff <= comment_in;
            acc_ff     <= acc_in;
            width_ff   <= width_in;
            height_ff  <= height_in;
            col_ff     <= col_in;
            row_ff     <= row_in;
            chan_ff    <= chan_in;
         end
      end
   end

endmodule

// ----- sv/ppm_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// PPM result queue
// Small register queue that takes up to two results per cycle and hands
// out one per transfer; reports whether two more results fit.
// ----------------------------------------------------------------------------
module ppm_rsp_queue #(
   parameter int unsigned DATA_BITS = ppm_pkg::rsp_bits(ppm_pkg::DIM_BITS_DEFAULT)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_cnt_i,
   input  logic [DATA_BITS-1:0] push0_i,
   input  logic [DATA_BITS-1:0] push1_i,
   output logic                 room_o,
   output logic                 out_valid_o,
   input  logic                 out_ready_i,
   output logic [DATA_BITS-1:0] out_data_o
);
   import ppm_pkg::*;

   localparam int unsigned PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_BITS-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CNT_BITS-1:0]  count_ff,  count_in;
   logic [PTR_BITS-1:0]  wr_ptr_next;
   logic                 pop;

   assign pop         = out_valid_o && out_ready_i;
   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   // advance pointers and occupancy
   assign rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
   assign wr_ptr_in = wr_ptr_ff + PTR_BITS'(push_cnt_i);
   assign count_in  = count_ff + CNT_BITS'(push_cnt_i) - CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // write one or two entries
   always_ff @(posedge clock) begin
      if (push_cnt_i != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0_i;
      end
      if (push_cnt_i == 2'd2) begin
         entry_ff[wr_ptr_next] <= push1_i;
      end
   end

   assign room_o      = count_ff <= CNT_BITS'(QUEUE_DEPTH - 2);
   assign out_valid_o = count_ff != '0;
   assign out_data_o  = entry_ff[rd_ptr_ff];

endmodule

// ----- sv/ppm_p6_stream_parser_top.sv -----
// ----------------------------------------------------------------------------
// PPM P6 stream parser
// Parses a binary PPM file byte by byte into a header result, tagged pixel
// bytes and error results.
// ----------------------------------------------------------------------------
// One file byte is taken per cycle, while req_ready is high, into an input
// register and worked by the parse engine once the queue has room; its
// results go into a four-entry result queue. With the queue empty, a byte
// passes from the input register into the queue, and its first result then
// shows on rsp_. A byte moves on from the input register whenever the queue
// holds at most two results, so with the result side ready the block
// sustains one byte per clock. A byte that gives two results (the header
// byte that is also the first pixel, or an end of file that adds an error
// after another result) leaves one more result queued; once three are
// queued the input register holds its byte while the result port drains.
// There is no start-up pass: the block is ready in the cycle after reset.
module ppm_p6_stream_parser_top #(
   parameter int unsigned DIM_BITS = ppm_pkg::DIM_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_end_of_file,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic [DIM_BITS-1:0] rsp_image_width_out,
   output logic [DIM_BITS-1:0] rsp_image_height_out,
   output logic [7:0]          rsp_pixel_value,
   output logic [1:0]          rsp_channel,
   output logic [DIM_BITS-1:0] rsp_column,
   output logic [DIM_BITS-1:0] rsp_row,
   output logic                rsp_last_of_image,
   output logic [2:0]          rsp_error_code,
   output logic                rsp_last_result
);
   import ppm_pkg::*;

   localparam int unsigned RSP_BITS = rsp_bits(DIM_BITS);

   typedef struct packed {
      logic [1:0]          kind;
      logic [DIM_BITS-1:0] width;
      logic [DIM_BITS-1:0] height;
      logic [7:0]          pixel;
      logic [1:0]          channel;
      logic [DIM_BITS-1:0] column;
      logic [DIM_BITS-1:0] row;
      logic                last_of_image;
      logic [2:0]          error_code;
      logic                last_result;
   } rsp_type;

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_eof_ff;
   logic                room;
   logic                step;
   logic                req_xfer;
   logic [1:0]          push_cnt;
   logic [RSP_BITS-1:0] push0;
   logic [RSP_BITS-1:0] push1;
   logic [RSP_BITS-1:0] head_bits;
   rsp_type             head;

   // input register: free it when the byte goes to the engine
   assign step        = in_valid_ff && room;
   assign req_ready   = !in_valid_ff || room;
   assign req_xfer    = req_valid && req_ready;
   assign in_valid_in = req_xfer || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // hold the byte of the current transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_data_byte;
         in_eof_ff  <= req_end_of_file;
      end
   end

   ppm_engine #(
      .DIM_BITS (DIM_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step_i     (step),
      .byte_i     (in_byte_ff),
      .eof_i      (in_eof_ff),
      .push_cnt_o (push_cnt),
      .rsp0_o     (push0),
      .rsp1_o     (push1)
   );

   ppm_rsp_queue #(
      .DATA_BITS (RSP_BITS)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_cnt_i  (push_cnt),
      .push0_i     (push0),
      .push1_i     (push1),
      .room_o      (room),
      .out_valid_o (rsp_valid),
      .out_ready_i (rsp_ready),
      .out_data_o  (head_bits)
   );

   // split the queue head onto the result ports
   assign head                 = head_bits;
   assign rsp_kind             = head.kind;
   assign rsp_image_width_out  = head.width;
   assign rsp_image_height_out = head.height;
   assign rsp_pixel_value      = head.pixel;
   assign rsp_channel          = head.channel;
   assign rsp_column           = head.column;
   assign rsp_row              = head.row;
   assign rsp_last_of_image    = head.last_of_image;
   assign rsp_error_code       = head.error_code;
   assign rsp_last_result      = head.last_result;

endmodule

// ----- sv/ppm_checker.sv -----
// ----------------------------------------------------------------------------
// PPM parser port checker
// Watches the parser's ports for result items that break the result rules,
// and is bound to the top level.
// ----------------------------------------------------------------------------
module ppm_checker #(
   parameter int unsigned DIM_BITS = ppm_pkg::DIM_BITS_DEFAULT
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [1:0]          rsp_kind,
   input logic [DIM_BITS-1:0] rsp_image_width_out,
   input logic [DIM_BITS-1:0] rsp_image_height_out,
   input logic [7:0]          rsp_pixel_value,
   input logic [1:0]          rsp_channel,
   input logic [DIM_BITS-1:0] rsp_column,
   input logic [DIM_BITS-1:0] rsp_row,
   input logic                rsp_last_of_image,
   input logic [2:0]          rsp_error_code,
   input logic                rsp_last_result
);
   import ppm_pkg::*;

   // nothing comes out in the cycle after reset
   a_quiet_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // a stalled result keeps its contents
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_pixel_value) && $stable(rsp_column) && $stable(rsp_row)
         && $stable(rsp_last_result))
      else $error("stalled result changed");

   // a header never reports an empty image
   a_header_size : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_HEADER |->
         rsp_image_width_out != '0 && rsp_image_height_out != '0)
      else $error("header with zero width or height");

   // the image closes on a blue byte that ends its input's results
   a_last_pixel : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_image |->
         rsp_kind == KIND_PIXEL && rsp_channel == CHAN_BLUE && rsp_last_result)
      else $error("bad end-of-image result");

   // an error is always the final result of its byte and has a known code
   a_error_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERROR |->
         rsp_last_result && rsp_error_code <= ERR_OVERFLOW)
      else $error("error result not last or with unknown code");

endmodule

bind ppm_p6_stream_parser_top ppm_checker #(.DIM_BITS(DIM_BITS)) u_checker (.*);
